// File: hdl/bca_pkg.sv
// ----------------------------------------------------------------------------
// Block allocator package
// Shared constants, command and status codes, and the word-scan hit type.
// ----------------------------------------------------------------------------
package bca_pkg;

  // Usage map word: blocks looked at per scan beat
  localparam int WORD_BITS  = 16;
  localparam int WORD_SEL_W = $clog2(WORD_BITS);

  localparam int DEFAULT_MAX_BLOCKS  = 4096;
  localparam int DEFAULT_BLOCK_BYTES = 4096;

  // Byte count plus rounding term needs one bit above 32
  localparam int NUMER_W = 33;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int USABLE_W   = 13;

  localparam logic [CFG_IDX_W-1:0] REG_USABLE_BLOCKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE     = 1'd1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE         = 2'd0;
  localparam logic [1:0] ST_ALLOC_FAIL   = 2'd1;
  localparam logic [1:0] ST_FREE_IGNORED = 2'd2;

  typedef struct packed {
    logic                  found;
    logic [WORD_SEL_W-1:0] bit_pos;
  } scan_hit_t;

endpackage

// File: hdl/bca_div.sv
// ----------------------------------------------------------------------------
// Block allocator divider
// Divides by the block size, a power of two, with a shift; the quotient is
// registered and done pulses in the cycle after start.
// ----------------------------------------------------------------------------
module bca_div #(
  parameter int DIVISOR = bca_pkg::DEFAULT_BLOCK_BYTES,
  parameter int NUM_W   = bca_pkg::NUMER_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int SH = $clog2(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // Hold the quotient until the next start
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= numer >> SH;
    end
  end

endmodule

// File: hdl/bca_scan.sv
// ----------------------------------------------------------------------------
// Block allocator word scan
// Extends the running free-run length across one map word, finds first fit.
// ----------------------------------------------------------------------------
module bca_scan #(
  parameter int IDX_W = 13
) (
  input  logic [bca_pkg::WORD_BITS-1:0] word,
  input  logic [IDX_W-1:0]              base,
  input  logic [IDX_W-1:0]              count,
  input  logic [IDX_W-1:0]              run_in,
  input  logic [IDX_W-1:0]              need,
  output bca_pkg::scan_hit_t            hit,
  output logic [IDX_W-1:0]              run_out
);
  import bca_pkg::*;

  localparam int SW = IDX_W + WORD_SEL_W + 1;

  logic [WORD_BITS-1:0] free_bit;
  logic [SW-1:0]        acc [WORD_BITS];

  always_comb begin
    // Blocks past the configured count count as used
    for (int j = 0; j < WORD_BITS; j++) begin
      free_bit[j] = !word[j] && ((SW'(base) + SW'(j)) < SW'(count));
    end
    // Run length ending at each bit: restart after the last used bit
    for (int j = 0; j < WORD_BITS; j++) begin
      acc[j] = SW'(run_in) + SW'(j) + SW'(1);
      for (int k = 0; k <= j; k++) begin
        if (!free_bit[k]) begin
          acc[j] = SW'(j - k);
        end
      end
    end
    hit = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (acc[j] >= SW'(need)) begin
        hit.found   = 1'b1;
        hit.bit_pos = WORD_SEL_W'(j);
      end
    end
    run_out = IDX_W'(acc[WORD_BITS-1]);
  end

endmodule

// File: hdl/bca_map.sv
// ----------------------------------------------------------------------------
// Block allocator usage map
// One bit per block, stored as words; one write and one registered read.
// ----------------------------------------------------------------------------
module bca_map #(
  parameter int ADDR_W = 8
) (
  input  logic                          clk,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [bca_pkg::WORD_BITS-1:0] rd_data,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [bca_pkg::WORD_BITS-1:0] wr_data
);
  import bca_pkg::*;

  logic [WORD_BITS-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/bitmap_contiguous_block_allocator_core.sv
// ----------------------------------------------------------------------------
// Bitmap contiguous block allocator core
// Steps: a free below base is answered from idle; other frees divide twice,
// then read and write back each word cleared; an allocate divides, fails on a
// bad size, scans one word per beat (up to WORDS = 256 at defaults), then marks.
// Throughput: one command at a time; busy drops in the cycle done pulses.
// Reset: map cleared by a sweep of 2**WA words (256 at defaults), busy high.
// The receiver cannot stall: done marks each result beat for one cycle.
// ----------------------------------------------------------------------------
module bitmap_contiguous_block_allocator_core #(
  parameter int MAX_BLOCKS  = bca_pkg::DEFAULT_MAX_BLOCKS,
  parameter int BLOCK_BYTES = bca_pkg::DEFAULT_BLOCK_BYTES
) (
  input  logic                            clk,
  input  logic                            rst,
  // command beat
  input  logic                            start,
  output logic                            busy,
  input  logic                            command,
  input  logic [31:0]                     size_bytes,
  input  logic [31:0]                     free_addr,
  // result beat
  output logic                            done,
  output logic [31:0]                     alloc_addr,
  output logic [1:0]                      status,
  // configuration writes
  input  logic                            cfg_write,
  input  logic [bca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bca_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bca_pkg::*;

  localparam int IXW   = $clog2(MAX_BLOCKS + 1);
  localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW    = WA + WORD_SEL_W;
  localparam int XW    = ((PW > IXW) ? PW : IXW) + 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV_SIZE,
    S_DIV_FIRST,
    S_SCAN_RD,
    S_SCAN,
    S_MOD_RD,
    S_MOD_WR,
    S_MUL,
    S_ADDR
  } state_t;

  state_t state;

  // Configuration registers
  logic [USABLE_W-1:0] usable_blocks;
  logic [31:0]         data_base;

  // Per-command registers
  logic               cmd_q;
  logic [31:0]        offset;
  logic [NUMER_W-1:0] nq;
  logic [IXW-1:0]     lo;
  logic [IXW-1:0]     len;
  logic [WA-1:0]      cur;
  logic [WA-1:0]      word_idx;
  logic [IXW-1:0]     run_len;
  logic [31:0]        prod;

  // Datapath nets
  logic [IXW-1:0]       blk_count;
  logic                 accept;
  logic                 below_base;
  logic                 div_start;
  logic [NUMER_W-1:0]   div_numer;
  logic                 div_done;
  logic [NUMER_W-1:0]   div_quot;
  logic [WA-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] mask;
  logic [IXW-1:0]       scan_base;
  scan_hit_t            hit;
  logic [IXW-1:0]       run_out;
  logic [IXW-1:0]       run_start;
  logic [XW-1:0]        end_x;
  logic [WA-1:0]        last_word;
  logic [IXW-1:0]       room;
  logic [IXW-1:0]       free_len;

  assign busy       = state != S_IDLE;
  assign accept     = start && (state == S_IDLE);
  assign below_base = free_addr < data_base;

  // Clamp the configured count to the map capacity
  always_comb begin
    if (32'(usable_blocks) > 32'(MAX_BLOCKS)) begin
      blk_count = IXW'(MAX_BLOCKS);
    end else begin
      blk_count = IXW'(usable_blocks);
    end
  end

  // Divider use: first the rounded-up block count, then the free start block
  always_comb begin
    if (state == S_IDLE) begin
      div_numer = NUMER_W'(size_bytes) + NUMER_W'(BLOCK_BYTES - 1);
    end else begin
      div_numer = NUMER_W'(offset);
    end
    div_start = (accept && !(command == CMD_FREE && below_base)) ||
                (state == S_DIV_SIZE && div_done && cmd_q == CMD_FREE);
  end

  bca_div #(
    .DIVISOR (BLOCK_BYTES),
    .NUM_W   (NUMER_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Scan reads run one word ahead of the word being examined
  always_comb begin
    case (state)
      S_SCAN_RD: rd_addr = '0;
      S_SCAN:    rd_addr = word_idx + WA'(1);
      default:   rd_addr = cur;
    endcase
  end

  // Bits of the current word that fall inside [lo, lo + len)
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (XW'({cur, {WORD_SEL_W{1'b0}}}) + XW'(b) >= XW'(lo)) &&
                (XW'({cur, {WORD_SEL_W{1'b0}}}) + XW'(b) < XW'(lo) + XW'(len));
    end
    end_x     = XW'(lo) + XW'(len) - XW'(1);
    last_word = WA'(end_x >> WORD_SEL_W);
  end

  assign wr_en = (state == S_MOD_WR) || (state == S_CLEAR);

  always_comb begin
    if (state == S_CLEAR) begin
      wr_data = '0;
    end else if (cmd_q == CMD_ALLOC) begin
      wr_data = rd_data | mask;
    end else begin
      wr_data = rd_data & ~mask;
    end
  end

  bca_map #(
    .ADDR_W (WA)
  ) u_map (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (cur),
    .wr_data (wr_data)
  );

  assign scan_base = IXW'({word_idx, {WORD_SEL_W{1'b0}}});

  bca_scan #(
    .IDX_W (IXW)
  ) u_scan (
    .word    (rd_data),
    .base    (scan_base),
    .count   (blk_count),
    .run_in  (run_len),
    .need    (len),
    .hit     (hit),
    .run_out (run_out)
  );

  // The run ends at the hit bit; step back over its length
  assign run_start = IXW'(XW'(scan_base) + XW'(hit.bit_pos) + XW'(1) - XW'(len));

  // Free range: clip to the blocks left before the count
  always_comb begin
    room = blk_count - IXW'(div_quot);
    if (nq > NUMER_W'(room)) begin
      free_len = room;
    end else begin
      free_len = IXW'(nq);
    end
  end

  // Configuration writes are taken in any state
  always_ff @(posedge clk) begin
    if (rst) begin
      usable_blocks <= USABLE_W'(4096);
      data_base     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_USABLE_BLOCKS: usable_blocks <= cfg_data[USABLE_W-1:0];
        REG_DATA_BASE:     data_base     <= cfg_data;
      endcase
    end
  end

  // Sequencer: state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cur        <= '0;
      done       <= 1'b0;
      alloc_addr <= '0;
      status     <= ST_DONE;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          // Sweep every map word to zero after reset
          cur <= cur + WA'(1);
          if (cur == {WA{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_q  <= command;
            offset <= free_addr - data_base;
            if (command == CMD_FREE && below_base) begin
              done       <= 1'b1;
              alloc_addr <= '0;
              status     <= ST_FREE_IGNORED;
            end else begin
              state <= S_DIV_SIZE;
            end
          end
        end
        S_DIV_SIZE: begin
          if (div_done) begin
            nq <= div_quot;
            if (cmd_q == CMD_FREE) begin
              state <= S_DIV_FIRST;
            end else if (div_quot == '0 || div_quot > NUMER_W'(blk_count)) begin
              done       <= 1'b1;
              alloc_addr <= '0;
              status     <= ST_ALLOC_FAIL;
              state      <= S_IDLE;
            end else begin
              len   <= IXW'(div_quot);
              state <= S_SCAN_RD;
            end
          end
        end
        S_DIV_FIRST: begin
          if (div_done) begin
            if (div_quot >= NUMER_W'(blk_count) || free_len == '0) begin
              // Nothing inside the count to clear
              done       <= 1'b1;
              alloc_addr <= '0;
              status     <= ST_DONE;
              state      <= S_IDLE;
            end else begin
              lo    <= IXW'(div_quot);
              len   <= free_len;
              cur   <= WA'(div_quot >> WORD_SEL_W);
              state <= S_MOD_RD;
            end
          end
        end
        S_SCAN_RD: begin
          word_idx <= '0;
          run_len  <= '0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          if (hit.found) begin
            lo    <= run_start;
            cur   <= WA'(run_start >> WORD_SEL_W);
            state <= S_MOD_RD;
          end else begin
            run_len <= run_out;
            if (word_idx == WA'(WORDS - 1)) begin
              done       <= 1'b1;
              alloc_addr <= '0;
              status     <= ST_ALLOC_FAIL;
              state      <= S_IDLE;
            end else begin
              word_idx <= word_idx + WA'(1);
            end
          end
        end
        S_MOD_RD: begin
          state <= S_MOD_WR;
        end
        S_MOD_WR: begin
          // Write back the merged word, then advance or finish
          if (cur == last_word) begin
            if (cmd_q == CMD_ALLOC) begin
              state <= S_MUL;
            end else begin
              done       <= 1'b1;
              alloc_addr <= '0;
              status     <= ST_DONE;
              state      <= S_IDLE;
            end
          end else begin
            cur   <= cur + WA'(1);
            state <= S_MOD_RD;
          end
        end
        S_MUL: begin
          prod  <= 32'(lo) * 32'(BLOCK_BYTES);
          state <= S_ADDR;
        end
        S_ADDR: begin
          done       <= 1'b1;
          alloc_addr <= data_base + prod;
          status     <= ST_DONE;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: test/tb_bitmap_contiguous_block_allocator_core.sv
// ----------------------------------------------------------------------------
// Bitmap contiguous block allocator core testbench
// Drives allocate and free commands through the start/busy port. A shadow
// usage map predicts the status and address of every command. Each done
// beat is checked against the oldest prediction. Directed corner cases come
// first, then random traffic over several map sizes and base offsets.
// ----------------------------------------------------------------------------
module tb_bitmap_contiguous_block_allocator_core;
  import bca_pkg::*;

  localparam int MAX_BLOCKS  = DEFAULT_MAX_BLOCKS;
  localparam int BLOCK_BYTES = DEFAULT_BLOCK_BYTES;
  // Worst command: full scan plus marking every map word, with margin
  localparam int SETTLE_CYCLES = 1000;

  typedef struct {
    logic [31:0] addr;
    logic [1:0]  st;
  } outcome_t;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] len;
  } run_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  command = CMD_ALLOC;
  logic [31:0]           size_bytes = '0;
  logic [31:0]           free_addr = '0;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_USABLE_BLOCKS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  busy;
  logic                  done;
  logic [31:0]           alloc_addr;
  logic [1:0]            status;

  // Shadow copy of the block: usage map and both registers
  bit                    shadow_map [MAX_BLOCKS];
  logic [USABLE_W-1:0]   shadow_usable = 13'd4096;
  logic [31:0]           shadow_base = '0;

  // Predicted outcomes of accepted commands, oldest first
  outcome_t              pending_outcomes[$];
  int                    mismatches = 0;

  always #5 clk = ~clk;

  bitmap_contiguous_block_allocator_core #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .size_bytes(size_bytes),
    .free_addr (free_addr),
    .done      (done),
    .alloc_addr(alloc_addr),
    .status    (status),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Shadow allocator
  // --------------------------------------------------------------------------

  // Counts above the map size saturate at the map size
  function automatic longint unsigned usable_count();
    longint unsigned n;
    n = shadow_usable;
    if (n > MAX_BLOCKS) n = MAX_BLOCKS;
    return n;
  endfunction

  // Round a byte length up to whole blocks; 33 bits of headroom needed
  function automatic longint unsigned blocks_covering(logic [31:0] bytes);
    longint unsigned wide;
    wide = bytes;
    return (wide + BLOCK_BYTES - 1) / BLOCK_BYTES;
  endfunction

  // Apply one command to the shadow map and work out its result beat
  function automatic outcome_t apply_command(logic cmd, logic [31:0] len,
                                             logic [31:0] from);
    outcome_t        o;
    longint unsigned need;
    longint unsigned count;
    longint unsigned run_start;
    longint unsigned run_len;
    longint unsigned first_blk;
    o.addr = '0;
    need   = blocks_covering(len);
    count  = usable_count();
    if (cmd == CMD_ALLOC) begin
      o.st = ST_ALLOC_FAIL;
      // Zero-size and oversized requests fail without touching the map
      if (need != 0 && need <= count) begin
        run_start = 0;
        run_len   = 0;
        // First fit: stop as soon as the run is long enough
        for (longint unsigned i = 0; i < count && run_len < need; i++) begin
          if (!shadow_map[i]) begin
            if (run_len == 0) run_start = i;
            run_len++;
          end else begin
            run_len = 0;
          end
        end
        if (run_len == need) begin
          for (longint unsigned i = 0; i < need; i++) shadow_map[run_start + i] = 1'b1;
          // Address wraps modulo 2**32
          o.addr = shadow_base + 32'(run_start * BLOCK_BYTES);
          o.st   = ST_DONE;
        end
      end
    end else if (from < shadow_base) begin
      o.st = ST_FREE_IGNORED;
    end else begin
      o.st      = ST_DONE;
      first_blk = 32'(from - shadow_base) / BLOCK_BYTES;
      // Clearing stops at the usable count; past the end clears nothing
      if (first_blk < count) begin
        if (need > count - first_blk) need = count - first_blk;
        for (longint unsigned i = 0; i < need; i++) shadow_map[first_blk + i] = 1'b0;
      end
    end
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got 0x%08h, want 0x%08h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Every done beat pairs with the oldest pending prediction
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result beat with nothing pending", alloc_addr, '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (alloc_addr !== want.addr) report_mismatch("alloc_addr", alloc_addr, want.addr);
        if (status !== want.st) report_mismatch("status", 32'(status), 32'(want.st));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drive helpers
  // --------------------------------------------------------------------------

  // Send one command beat; hold start high so a zero gap gives back-to-back
  // beats, and drop it only when the sender idles
  task automatic send_command(input logic cmd, input logic [31:0] len,
                              input logic [31:0] from, input bit no_gap,
                              output outcome_t o);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    command    <= cmd;
    size_bytes <= len;
    free_addr  <= from;
    // Accepted at the first edge where busy is low
    do @(posedge clk); while (busy !== 1'b0);
    o = apply_command(cmd, len, from);
    pending_outcomes.push_back(o);
  endtask

  task automatic send_beat(input logic cmd, input logic [31:0] len, input logic [31:0] from);
    outcome_t o;
    send_command(cmd, len, from, 1'b0, o);
  endtask

  // Drop start and hold off until every pending result is back
  task automatic pause_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0 || busy !== 1'b0);
  endtask

  // Write both registers while the block is idle
  task automatic write_registers(input logic [USABLE_W-1:0] usable, input logic [31:0] base);
    pause_until_drained();
    cfg_write <= 1'b1;
    cfg_index <= REG_USABLE_BLOCKS;
    cfg_data  <= CFG_DATA_W'(usable);
    @(posedge clk);
    cfg_index <= REG_DATA_BASE;
    cfg_data  <= base;
    @(posedge clk);
    cfg_write     <= 1'b0;
    shadow_usable  = usable;
    shadow_base    = base;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: 4096 blocks at base 0
  task automatic test_alloc_free_basics();
    send_beat(CMD_ALLOC, 32'd0, '0);                          // zero size fails
    send_beat(CMD_ALLOC, 32'd1, '0);                          // one block at 0
    send_beat(CMD_ALLOC, 32'd4096, '0);                       // exact block
    send_beat(CMD_ALLOC, 32'd4097, '0);                       // rounds up to two
    send_beat(CMD_ALLOC, 32'hFFFF_FFFF, '0);                  // more than the map
    send_beat(CMD_ALLOC, 32'h0100_0000, '0);                  // whole map, no room
    send_beat(CMD_FREE, 32'd4096, 32'd4096);                  // open a hole at 1
    send_beat(CMD_ALLOC, 32'd1, '0);                          // first fit reuses it
    send_beat(CMD_FREE, 32'd0, 32'd0);                        // zero-size free
    send_beat(CMD_FREE, 32'd1, 32'(100 * BLOCK_BYTES));       // already free
    send_beat(CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);        // starts past the end
    send_beat(CMD_FREE, 32'hFFFF_FFFF, 32'd0);                // clear everything
    send_beat(CMD_ALLOC, 32'h0100_0000, '0);                  // fill the whole map
    send_beat(CMD_ALLOC, 32'd1, '0);                          // full map fails
    send_beat(CMD_FREE, 32'd8192, 32'(4095 * BLOCK_BYTES));   // clipped at the end
    send_beat(CMD_ALLOC, 32'd8192, '0);                       // only one block free
    send_beat(CMD_ALLOC, 32'd4096, '0);                       // last block
  endtask

  task automatic test_register_extremes();
    // Count above the map saturates; base near the top wraps addresses
    write_registers(13'h1FFF, 32'hFFFF_F000);
    send_beat(CMD_FREE, 32'd4096, 32'd0);                     // below base: ignored
    send_beat(CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_F000);        // clear everything
    send_beat(CMD_ALLOC, 32'd8192, '0);                       // at base
    send_beat(CMD_ALLOC, 32'd1, '0);                          // wraps past 2**32
    // Empty map: every allocate fails, every free is past the end
    write_registers(13'd0, 32'd0);
    send_beat(CMD_ALLOC, 32'd1, '0);
    send_beat(CMD_FREE, 32'd4096, 32'd0);
    // Single block
    write_registers(13'd1, 32'd0);
    send_beat(CMD_ALLOC, 32'd1, '0);                          // block 0 still used
    send_beat(CMD_FREE, 32'd4096, 32'd0);
    send_beat(CMD_ALLOC, 32'd4096, '0);
  endtask

  // Mostly allocate/free pairs on live runs, some noise and pauses
  task automatic run_traffic_phase(input int n_items, input logic [USABLE_W-1:0] usable,
                                   input logic [31:0] base, input bit burst);
    run_t            live[$];
    run_t            r;
    outcome_t        o;
    int              kind;
    int              idx;
    longint unsigned span;
    logic [31:0]     len;
    logic [31:0]     from;
    logic            cmd;
    write_registers(usable, base);
    span = (usable_count() + 1) * BLOCK_BYTES;
    for (int n = 0; n < n_items; n++) begin
      kind = $urandom_range(0, 99);
      from = $urandom();
      if (kind < 45 || (kind < 85 && live.size() == 0)) begin
        cmd = CMD_ALLOC;
        // Now and then a request near the size of the whole map
        if ($urandom_range(0, 19) == 0) len = $urandom_range(1, 32'(span));
        else len = $urandom_range(1, 6 * BLOCK_BYTES);
      end else if (kind < 85) begin
        // Release a live run, at any byte inside its first block
        cmd  = CMD_FREE;
        idx  = $urandom_range(0, live.size() - 1);
        r    = live[idx];
        live.delete(idx);
        len  = r.len;
        from = r.addr + $urandom_range(0, BLOCK_BYTES - 1);
      end else begin
        cmd = 1'($urandom_range(0, 1));
        len = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 3 * BLOCK_BYTES);
      end
      send_command(cmd, len, from, burst, o);
      if (cmd == CMD_ALLOC && o.st == ST_DONE) begin
        r.addr = o.addr;
        r.len  = len;
        live.push_back(r);
      end
      if ($urandom_range(0, 49) == 0) pause_until_drained();
    end
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(250, 13'd4096, 32'd0, 1'b0);
    run_traffic_phase(250, 13'd64, 32'h0001_0000, 1'b0);
    run_traffic_phase(250, 13'h1FFF, $urandom(), 1'b1);
    run_traffic_phase(200, 13'd16, 32'hFFFF_8000, 1'b0);
    run_traffic_phase(60, 13'd0, $urandom(), 1'b0);
    run_traffic_phase(100, 13'd1, 32'd0, 1'b1);
    run_traffic_phase(250, 13'($urandom_range(0, 8191)), $urandom(), 1'b0);
    run_traffic_phase(200, 13'd300, 32'hFFFF_FFFF, 1'b0);
    run_traffic_phase(250, 13'd4096, 32'd0, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // Block clears its map after reset; the first beat waits on busy
    test_alloc_free_basics();
    test_register_extremes();
    test_random_traffic();
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hang guard: far above the slowest correct run
  initial begin
    #80_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
hdl/bca_pkg.sv
hdl/bca_div.sv
hdl/bca_scan.sv
hdl/bca_map.sv
hdl/bitmap_contiguous_block_allocator_core.sv
test/tb_bitmap_contiguous_block_allocator_core.sv
